>>> hdl/rpyr_pkg.sv
package rpyr_pkg;

    localparam int IN_W       = 16;
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_W      = FRAC_BITS + 2;
    localparam int RND_SH     = 31 - FRAC_BITS;

    localparam logic [31:0] HALF_PI_Q31 = 32'd3373259426;
    localparam logic [31:0] Q31_ONE     = 32'h8000_0000;

    localparam int HORNER_STEPS = 7;
    localparam int LANE_LAT     = 18;
    localparam int MAT_LAT      = 4;
    localparam int LATENCY      = LANE_LAT + MAT_LAT;

    // exact floor(v / k) for v < 2^31 as (v * ceil(2^sh / k)) >> sh
    localparam int SIN_SHIFT [6] = '{39, 38, 38, 37, 36, 34};
    localparam logic [32:0] SIN_RECIP [6] = '{
        33'(((64'd1 << 39) + 64'd155) / 64'd156),
        33'(((64'd1 << 38) + 64'd109) / 64'd110),
        33'(((64'd1 << 38) + 64'd71) / 64'd72),
        33'(((64'd1 << 37) + 64'd41) / 64'd42),
        33'(((64'd1 << 36) + 64'd19) / 64'd20),
        33'(((64'd1 << 34) + 64'd5) / 64'd6)
    };
    localparam int COS_SHIFT [7] = '{39, 39, 38, 37, 36, 35, 32};
    localparam logic [32:0] COS_RECIP [7] = '{
        33'(((64'd1 << 39) + 64'd181) / 64'd182),
        33'(((64'd1 << 39) + 64'd131) / 64'd132),
        33'(((64'd1 << 38) + 64'd89) / 64'd90),
        33'(((64'd1 << 37) + 64'd55) / 64'd56),
        33'(((64'd1 << 36) + 64'd29) / 64'd30),
        33'(((64'd1 << 35) + 64'd11) / 64'd12),
        33'(((64'd1 << 32) + 64'd1) / 64'd2)
    };

    typedef logic signed [32:0] q31_t;
    typedef logic signed [33:0] sum_t;

    typedef struct packed {
        q31_t sn;
        q31_t cs;
    } trig_t;

    // q31 product, magnitude rounded half away from zero
    function automatic q31_t mulq(input q31_t a, input q31_t b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] pr;
        logic [32:0] m;
        ma = a[32] ? 32'(-a) : a[31:0];
        mb = b[32] ? 32'(-b) : b[31:0];
        pr = 64'(ma) * 64'(mb) + (64'd1 << 30);
        m  = {1'b0, pr[62:31]};
        return (a[32] != b[32]) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input sum_t v);
        logic [33:0] mag;
        logic [33:0] r;
        logic [33:0] res;
        mag = v[33] ? 34'(-v) : 34'(v);
        r = (mag + (34'd1 << (RND_SH - 1))) >> RND_SH;
        if (r > (34'd1 << FRAC_BITS))
        begin
            r = 34'd1 << FRAC_BITS;
        end
        res = v[33] ? -r : r;
        return res[OUT_W-1:0];
    endfunction

endpackage

>>> hdl/rpyr_sincos.sv
module rpyr_sincos (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rpyr_pkg::IN_W-1:0]  angle,
    output rpyr_pkg::trig_t            trig
);

    localparam int NS = rpyr_pkg::HORNER_STEPS;

    logic [31:0] phase;
    logic [29:0] rem;
    logic [29:0] u_next;

    logic [29:0] u_reg;
    logic [31:0] x_reg;
    logic [31:0] x2_pipe_reg [2*(NS-1)+1];
    logic [31:0] x_pipe_reg [2*(NS-1)+1];
    logic [2:0]  ctl_reg [rpyr_pkg::LANE_LAT-1];
    logic [31:0] va_s_reg [NS];
    logic [31:0] va_c_reg [NS];
    logic [31:0] tb_s_reg [NS];
    logic [31:0] tb_c_reg [NS];
    rpyr_pkg::trig_t trig_reg;

    logic [31:0] s0;
    logic [31:0] c0;
    rpyr_pkg::q31_t ps;
    rpyr_pkg::q31_t pc;
    rpyr_pkg::trig_t trig_next;

    assign phase  = {angle[rpyr_pkg::ANGLE_BITS-1:0], {(32-rpyr_pkg::ANGLE_BITS){1'b0}}};
    assign rem    = phase[29:0];
    // second half of the quadrant folds back, sine and cosine swap
    assign u_next = rem[29] ? 30'(31'h4000_0000 - {1'b0, rem}) : rem;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg      <= u_next;
            ctl_reg[0] <= {phase[31:30], rem[29]};
            for (int i = 1; i < rpyr_pkg::LANE_LAT - 1; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            x_reg          <= 32'((64'(u_reg) * 64'(rpyr_pkg::HALF_PI_Q31)) >> 30);
            x2_pipe_reg[0] <= 32'((64'(x_reg) * 64'(x_reg)) >> 31);
            x_pipe_reg[0]  <= x_reg;
            for (int i = 1; i < 2*(NS-1)+1; i++)
            begin
                x2_pipe_reg[i] <= x2_pipe_reg[i-1];
                x_pipe_reg[i]  <= x_pipe_reg[i-1];
            end
        end
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_step
        logic [31:0] t_s;
        logic [31:0] t_c;
        assign t_s = (j == 0) ? rpyr_pkg::Q31_ONE : tb_s_reg[(j == 0) ? 0 : j-1];
        assign t_c = (j == 0) ? rpyr_pkg::Q31_ONE : tb_c_reg[(j == 0) ? 0 : j-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                va_c_reg[j] <= 32'((64'(x2_pipe_reg[2*j]) * 64'(t_c)) >> 31);
                tb_c_reg[j] <= rpyr_pkg::Q31_ONE - 32'((65'(va_c_reg[j])
                               * 65'(rpyr_pkg::COS_RECIP[j])) >> rpyr_pkg::COS_SHIFT[j]);
            end
        end

        if (j < NS - 1)
        begin : g_sin
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    va_s_reg[j] <= 32'((64'(x2_pipe_reg[2*j]) * 64'(t_s)) >> 31);
                    tb_s_reg[j] <= rpyr_pkg::Q31_ONE - 32'((65'(va_s_reg[j])
                                   * 65'(rpyr_pkg::SIN_RECIP[j])) >> rpyr_pkg::SIN_SHIFT[j]);
                end
            end
        end
        else
        begin : g_sin_last
            // sine series ends with one multiply by x
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    va_s_reg[j] <= 32'((64'(x_pipe_reg[2*j]) * 64'(t_s)) >> 31);
                    tb_s_reg[j] <= va_s_reg[j];
                end
            end
        end
    end

    always_comb
    begin
        s0 = ctl_reg[rpyr_pkg::LANE_LAT-2][0] ? tb_c_reg[NS-1] : tb_s_reg[NS-1];
        c0 = ctl_reg[rpyr_pkg::LANE_LAT-2][0] ? tb_s_reg[NS-1] : tb_c_reg[NS-1];
        ps = $signed({1'b0, s0});
        pc = $signed({1'b0, c0});
        case (ctl_reg[rpyr_pkg::LANE_LAT-2][2:1])
            2'd0:
            begin
                trig_next.sn = ps;
                trig_next.cs = pc;
            end
            2'd1:
            begin
                trig_next.sn = pc;
                trig_next.cs = -ps;
            end
            2'd2:
            begin
                trig_next.sn = -ps;
                trig_next.cs = -pc;
            end
            default:
            begin
                trig_next.sn = -pc;
                trig_next.cs = ps;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

>>> hdl/rpyr_matrix.sv
module rpyr_matrix (
    input  logic                         clk,
    input  logic                         en,
    input  rpyr_pkg::trig_t              roll,
    input  rpyr_pkg::trig_t              pitch,
    input  rpyr_pkg::trig_t              yaw,
    output logic [rpyr_pkg::OUT_W-1:0]   m [9]
);

    rpyr_pkg::q31_t cycp_reg, cysp_reg, sycr_reg, sysr_reg, sycp_reg;
    rpyr_pkg::q31_t sysp_reg, cycr_reg, cysr_reg, cpsr_reg, cpcr_reg;
    rpyr_pkg::q31_t sr_reg, cr_reg, sp_reg;

    rpyr_pkg::q31_t a1_reg, a2_reg, a3_reg, a4_reg;
    rpyr_pkg::q31_t cycp2_reg, sycr2_reg, sysr2_reg, sycp2_reg;
    rpyr_pkg::q31_t cycr2_reg, cysr2_reg, cpsr2_reg, cpcr2_reg, sp2_reg;

    rpyr_pkg::sum_t v_reg [9];
    logic [rpyr_pkg::OUT_W-1:0] m_reg [9];

    function automatic rpyr_pkg::sum_t ext(input rpyr_pkg::q31_t a);
        return {a[32], a};
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycp_reg <= rpyr_pkg::mulq(yaw.cs, pitch.cs);
            cysp_reg <= rpyr_pkg::mulq(yaw.cs, pitch.sn);
            sycr_reg <= rpyr_pkg::mulq(yaw.sn, roll.cs);
            sysr_reg <= rpyr_pkg::mulq(yaw.sn, roll.sn);
            sycp_reg <= rpyr_pkg::mulq(yaw.sn, pitch.cs);
            sysp_reg <= rpyr_pkg::mulq(yaw.sn, pitch.sn);
            cycr_reg <= rpyr_pkg::mulq(yaw.cs, roll.cs);
            cysr_reg <= rpyr_pkg::mulq(yaw.cs, roll.sn);
            cpsr_reg <= rpyr_pkg::mulq(pitch.cs, roll.sn);
            cpcr_reg <= rpyr_pkg::mulq(pitch.cs, roll.cs);
            sr_reg   <= roll.sn;
            cr_reg   <= roll.cs;
            sp_reg   <= pitch.sn;

            // triple products, left to right
            a1_reg    <= rpyr_pkg::mulq(cysp_reg, sr_reg);
            a2_reg    <= rpyr_pkg::mulq(cysp_reg, cr_reg);
            a3_reg    <= rpyr_pkg::mulq(sysp_reg, sr_reg);
            a4_reg    <= rpyr_pkg::mulq(sysp_reg, cr_reg);
            cycp2_reg <= cycp_reg;
            sycr2_reg <= sycr_reg;
            sysr2_reg <= sysr_reg;
            sycp2_reg <= sycp_reg;
            cycr2_reg <= cycr_reg;
            cysr2_reg <= cysr_reg;
            cpsr2_reg <= cpsr_reg;
            cpcr2_reg <= cpcr_reg;
            sp2_reg   <= sp_reg;

            v_reg[0] <= ext(cycp2_reg);
            v_reg[1] <= ext(a1_reg) - ext(sycr2_reg);
            v_reg[2] <= ext(a2_reg) + ext(sysr2_reg);
            v_reg[3] <= ext(sycp2_reg);
            v_reg[4] <= ext(a3_reg) + ext(cycr2_reg);
            v_reg[5] <= ext(a4_reg) - ext(cysr2_reg);
            v_reg[6] <= -ext(sp2_reg);
            v_reg[7] <= ext(cpsr2_reg);
            v_reg[8] <= ext(cpcr2_reg);

            for (int i = 0; i < 9; i++)
            begin
                m_reg[i] <= rpyr_pkg::to_out(v_reg[i]);
            end
        end
    end

    assign m = m_reg;

endmodule

>>> hdl/roll_pitch_yaw_to_rotation.sv
// throughput: one request per cycle unless a result waits on out_ready; each angle has its own sine/cosine lane, the
// lanes feed a shared four-stage matrix product pipeline
// the whole pipeline holds while a result waits on out_ready
// reset (rst_n, async, active low) clears only the valid bits; data regs are not reset
module roll_pitch_yaw_to_rotation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rpyr_pkg::IN_W-1:0]    roll_angle,
    input  logic signed [rpyr_pkg::IN_W-1:0]    pitch_angle,
    input  logic signed [rpyr_pkg::IN_W-1:0]    yaw_angle,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rpyr_pkg::OUT_W-1:0]   m00,
    output logic signed [rpyr_pkg::OUT_W-1:0]   m01,
    output logic signed [rpyr_pkg::OUT_W-1:0]   m02,
    output logic signed [rpyr_pkg::OUT_W-1:0]   m10,
    output logic signed [rpyr_pkg::OUT_W-1:0]   m11,
    output logic signed [rpyr_pkg::OUT_W-1:0]   m12,
    output logic signed [rpyr_pkg::OUT_W-1:0]   m20,
    output logic signed [rpyr_pkg::OUT_W-1:0]   m21,
    output logic signed [rpyr_pkg::OUT_W-1:0]   m22
);

    logic en;
    logic [rpyr_pkg::LATENCY-1:0] vld_reg;
    logic [rpyr_pkg::LATENCY-1:0] vld_next;
    rpyr_pkg::trig_t tr_r;
    rpyr_pkg::trig_t tr_p;
    rpyr_pkg::trig_t tr_y;
    logic [rpyr_pkg::OUT_W-1:0] mat [9];

    assign en        = !vld_reg[rpyr_pkg::LATENCY-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[rpyr_pkg::LATENCY-1];
    assign vld_next  = {vld_reg[rpyr_pkg::LATENCY-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    rpyr_sincos u_lane_roll (
        .clk   (clk),
        .en    (en),
        .angle (roll_angle),
        .trig  (tr_r)
    );

    rpyr_sincos u_lane_pitch (
        .clk   (clk),
        .en    (en),
        .angle (pitch_angle),
        .trig  (tr_p)
    );

    rpyr_sincos u_lane_yaw (
        .clk   (clk),
        .en    (en),
        .angle (yaw_angle),
        .trig  (tr_y)
    );

    rpyr_matrix u_matrix (
        .clk   (clk),
        .en    (en),
        .roll  (tr_r),
        .pitch (tr_p),
        .yaw   (tr_y),
        .m     (mat)
    );

    assign m00 = $signed(mat[0]);
    assign m01 = $signed(mat[1]);
    assign m02 = $signed(mat[2]);
    assign m10 = $signed(mat[3]);
    assign m11 = $signed(mat[4]);
    assign m12 = $signed(mat[5]);
    assign m20 = $signed(mat[6]);
    assign m21 = $signed(mat[7]);
    assign m22 = $signed(mat[8]);

`ifndef SYNTHESIS
    localparam logic signed [rpyr_pkg::OUT_W-1:0] LIM = rpyr_pkg::OUT_W'(1 << rpyr_pkg::FRAC_BITS);

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

    a_m00_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (m00 <= LIM && m00 >= -LIM))
        else $error("m00 outside unit range");

    a_m11_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (m11 <= LIM && m11 >= -LIM))
        else $error("m11 outside unit range");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_RANDOM = 650;

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
    } angles_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [rpyr_pkg::IN_W-1:0] roll_angle;
    logic signed [rpyr_pkg::IN_W-1:0] pitch_angle;
    logic signed [rpyr_pkg::IN_W-1:0] yaw_angle;
    logic out_valid;
    logic out_ready;
    logic signed [rpyr_pkg::OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    angles_t pending_requests[$];
    logic [9*rpyr_pkg::OUT_W-1:0] expected_matrices[$];
    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int idle_cycles;

    roll_pitch_yaw_to_rotation dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
        .out_valid(out_valid), .out_ready(out_ready),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // sine and cosine of a reduced phase in [0, 2^29], unsigned q31
    task automatic quadrant_trig(input logic [63:0] u, output logic [63:0] s,
                                 output logic [63:0] c);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sdiv [6];
        logic [63:0] cdiv [7];
        sdiv = '{156, 110, 72, 42, 20, 6};
        cdiv = '{182, 132, 90, 56, 30, 12, 2};
        x = (u * 64'd3373259426) >> 30;
        x2 = (x * x) >> 31;
        t = 64'h8000_0000;
        for (int i = 0; i < 6; i++)
            t = 64'h8000_0000 - ((x2 * t) >> 31) / sdiv[i];
        s = (x * t) >> 31;
        t = 64'h8000_0000;
        for (int i = 0; i < 7; i++)
            t = 64'h8000_0000 - ((x2 * t) >> 31) / cdiv[i];
        c = t;
    endtask

    task automatic angle_sincos(input logic [15:0] a, output longint sn, output longint cs);
        logic [31:0] p;
        logic [29:0] r;
        logic [63:0] s0;
        logic [63:0] c0;
        p = {a, 16'd0};
        r = p[29:0];
        if (r < (30'd1 << 29))
            quadrant_trig(64'(r), s0, c0);
        else
            quadrant_trig((64'd1 << 30) - 64'(r), c0, s0);
        case (p[31:30])
            2'd0: begin sn = s0; cs = c0; end
            2'd1: begin sn = c0; cs = -longint'(s0); end
            2'd2: begin sn = -longint'(s0); cs = -longint'(c0); end
            default: begin sn = -longint'(c0); cs = s0; end
        endcase
    endtask

    function automatic longint qmul(input longint a, input longint b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] m;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        m = (ma * mb + (64'd1 << 30)) >> 31;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [rpyr_pkg::OUT_W-1:0] round_q16(input longint v);
        logic [63:0] m;
        longint r;
        m = v < 0 ? -v : v;
        m = (m + 64'd16384) >> 15;
        if (m > 64'd65536)
            m = 64'd65536;
        r = v < 0 ? -longint'(m) : longint'(m);
        return r[rpyr_pkg::OUT_W-1:0];
    endfunction

    task automatic predict_rotation(input angles_t a,
                                    output logic [9*rpyr_pkg::OUT_W-1:0] packed_m);
        longint sr, cr, sp, cp, sy, cy;
        longint v [9];
        angle_sincos(a.roll, sr, cr);
        angle_sincos(a.pitch, sp, cp);
        angle_sincos(a.yaw, sy, cy);
        v[0] = qmul(cy, cp);
        v[1] = qmul(qmul(cy, sp), sr) - qmul(sy, cr);
        v[2] = qmul(qmul(cy, sp), cr) + qmul(sy, sr);
        v[3] = qmul(sy, cp);
        v[4] = qmul(qmul(sy, sp), sr) + qmul(cy, cr);
        v[5] = qmul(qmul(sy, sp), cr) - qmul(cy, sr);
        v[6] = -sp;
        v[7] = qmul(cp, sr);
        v[8] = qmul(cp, cr);
        for (int i = 0; i < 9; i++)
            packed_m[(8-i)*rpyr_pkg::OUT_W +: rpyr_pkg::OUT_W] = round_q16(v[i]);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic [9*rpyr_pkg::OUT_W-1:0] exp_m;
        angles_t next;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            roll_angle <= '0;
            pitch_angle <= '0;
            yaw_angle <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_rotation({roll_angle, pitch_angle, yaw_angle}, exp_m);
                expected_matrices.push_back(exp_m);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    roll_angle <= next.roll;
                    pitch_angle <= next.pitch;
                    yaw_angle <= next.yaw;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic [9*rpyr_pkg::OUT_W-1:0] exp_m;
        logic [9*rpyr_pkg::OUT_W-1:0] got_m;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            idle_cycles <= 0;
            mismatch_count = 0;
        end
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                got_m = {m00, m01, m02, m10, m11, m12, m20, m21, m22};
                if (expected_matrices.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", got_m);
                end
                else
                begin
                    exp_m = expected_matrices.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got_m[(8-i)*rpyr_pkg::OUT_W +: rpyr_pkg::OUT_W]
                            !== exp_m[(8-i)*rpyr_pkg::OUT_W +: rpyr_pkg::OUT_W])
                        begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("m%0d%0d expected %h got %h", i / 3, i % 3,
                                         exp_m[(8-i)*rpyr_pkg::OUT_W +: rpyr_pkg::OUT_W],
                                         got_m[(8-i)*rpyr_pkg::OUT_W +: rpyr_pkg::OUT_W]);
                        end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic add_request(input logic [15:0] r, input logic [15:0] p, input logic [15:0] y);
        pending_requests.push_back({r, p, y});
    endtask

    function automatic logic [15:0] random_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(7)) << 13;
            1: return (16'($urandom_range(7)) << 13) + 16'($urandom_range(4)) - 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] corners [8];
        corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                    16'h7FFF, 16'h8001, 16'h2000, 16'hFFFF};
        rst_n = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 61;
        // quadrant edges, octant fold, extremes
        for (int i = 0; i < 8; i++)
            add_request(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
        add_request(16'h1FFF, 16'h2001, 16'h5555);
        add_request(16'h4000, 16'h4000, 16'h4000);
        add_request(16'hC000, 16'hC000, 16'h8000);
        add_request(16'hAAAA, 16'h5555, 16'h0001);
        add_request(16'h3FFF, 16'hBFFF, 16'h6000);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int i = 0; i < NUM_RANDOM / 3; i++)
                add_request(random_angle(), random_angle(), random_angle());
            wait (pending_requests.size() == 0 && !in_valid && expected_matrices.size() == 0);
            if (phase == 0)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        repeat (rpyr_pkg::LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && expected_matrices.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hdl/rpyr_pkg.sv
hdl/rpyr_sincos.sv
hdl/rpyr_matrix.sv
hdl/roll_pitch_yaw_to_rotation.sv
tb/sv/tb_top.sv
